// ----- sv/bmnm_pkg.sv -----
// Shared widths, reset values, register codes and the reciprocal table of the mean filter.
`timescale 1ns / 1ps

package bmnm_pkg;

    // Default grid limits handed to the top level
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    // Field widths
    localparam int PIXEL_W     = 16;
    localparam int OUT_POS_W   = 6;
    localparam int GRID_SIZE_W = 7;
    localparam int CENTRE_W    = 12;
    localparam int STEP_W      = 8;
    localparam int BAND_W      = 13;

    // Neighbours at or below this value are left out of the mean
    localparam logic [PIXEL_W-1:0] THRESHOLD = 16'd4;

    // Mean unit: nine 16-bit terms, a count of 1..9, reciprocals scaled by 2^28
    localparam int SUM_W     = 20;
    localparam int CNT_W     = 4;
    localparam int RECIP_W   = 29;
    localparam int DIV_SHIFT = 28;
    localparam int PROD_W    = SUM_W + RECIP_W;

    // Register port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register reset values
    localparam logic [GRID_SIZE_W-1:0] RST_GRID_COLS      = 7'd64;
    localparam logic [GRID_SIZE_W-1:0] RST_GRID_ROWS      = 7'd64;
    localparam logic [CENTRE_W-1:0]    RST_X_FIRST_CENTRE = 12'd0;
    localparam logic [CENTRE_W-1:0]    RST_Y_FIRST_CENTRE = 12'd0;
    localparam logic [STEP_W-1:0]      RST_BIN_STEP       = 8'd25;
    localparam logic signed [BAND_W-1:0] RST_BAND_LOW     = 13'sd148;
    localparam logic signed [BAND_W-1:0] RST_BAND_HIGH    = 13'sd202;
    localparam logic [CENTRE_W-1:0]    RST_X_LIMIT        = 12'd452;

    // Register indexes, in address order
    typedef enum logic [2:0] {
        REG_GRID_COLS,
        REG_GRID_ROWS,
        REG_X_FIRST_CENTRE,
        REG_Y_FIRST_CENTRE,
        REG_BIN_STEP,
        REG_BAND_LOW,
        REG_BAND_HIGH,
        REG_X_LIMIT
    } cfg_reg_t;

    // Rounded-up reciprocal of the neighbour count, ceil(2^28 / n).
    // The rounding error times the largest sum stays far below 2^28,
    // so the scaled product truncates to the exact quotient.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd1:    r = 29'd268435456;
            4'd2:    r = 29'd134217728;
            4'd3:    r = 29'd89478486;
            4'd4:    r = 29'd67108864;
            4'd5:    r = 29'd53687092;
            4'd6:    r = 29'd44739243;
            4'd7:    r = 29'd38347923;
            4'd8:    r = 29'd33554432;
            4'd9:    r = 29'd29826162;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/bmnm_if.sv -----
// Valid/ready channel interfaces for grid cells in and filtered results out.
`timescale 1ns / 1ps

interface bmnm_in_if;
    import bmnm_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface bmnm_out_if;
    import bmnm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_POS_W-1:0] out_row;
    logic [OUT_POS_W-1:0] out_col;
    logic [PIXEL_W-1:0]   out_value;
    logic                 was_filled;
    logic                 no_neighbour;
    logic                 frame_last;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output was_filled, output no_neighbour, output frame_last,
                    input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input was_filled, input no_neighbour, input frame_last,
                    output ready);
endinterface

// ----- sv/bmnm_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps

module bmnm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write when enabled; the read port samples every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- sv/banded_masked_neighbour_mean.sv -----
// Top level of the banded, masked 3x3 neighbour mean filter over a raster stream.
//
//   Channel   Direction  Handshake         Payload
//   pixels    in         valid / ready     pixel_value (unsigned Q4.12)
//   results   out        valid / ready     out_row, out_col, out_value, was_filled,
//                                          no_neighbour, frame_last
//   APB       in         psel / penable    eight registers at byte address 4*i
//
// A new item is accepted only in the idle state: the sequencer then loads the window and,
// for each of the n results the item releases (0 to 4), sums, divides and presents it,
// holding it while the result side stalls. This order is set by the single port of each
// line buffer (read, then write back) and by one shared mean unit, one result at a time.
// Reset clears the counters, the sequencer and the registers; the line buffers need no
// clearing, since entries never written are only read for neighbours outside the grid.
`timescale 1ns / 1ps

module banded_masked_neighbour_mean #(
    parameter int MAX_COLS = bmnm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = bmnm_pkg::DEF_MAX_ROWS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bmnm_pkg::APB_AW-1:0] paddr,
    input  logic [bmnm_pkg::APB_DW-1:0] pwdata,
    output logic [bmnm_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    bmnm_in_if.sink                     pixels,
    bmnm_out_if.source                  results
);

    import bmnm_pkg::*;

    localparam int CW     = $clog2(MAX_COLS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int SZCW   = (CW + 1 > GRID_SIZE_W) ? CW + 1 : GRID_SIZE_W;
    localparam int SZRW   = (RW + 1 > GRID_SIZE_W) ? RW + 1 : GRID_SIZE_W;
    localparam int CXW    = SZCW + 1;
    localparam int RXW    = SZRW + 1;
    localparam int MW     = (CW > RW) ? CW : RW;
    localparam int PW     = MW + 14;
    localparam int COL_XW = CW + OUT_POS_W;
    localparam int ROW_XW = RW + OUT_POS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

    // Configuration registers
    logic [GRID_SIZE_W-1:0]     grid_cols_reg;
    logic [GRID_SIZE_W-1:0]     grid_rows_reg;
    logic [CENTRE_W-1:0]        x_first_centre_reg;
    logic [CENTRE_W-1:0]        y_first_centre_reg;
    logic [STEP_W-1:0]          bin_step_reg;
    logic signed [BAND_W-1:0]   band_low_reg;
    logic signed [BAND_W-1:0]   band_high_reg;
    logic [CENTRE_W-1:0]        x_limit_reg;
    logic                       cfg_write;
    cfg_reg_t                   cfg_sel;

    // Control state
    state_t                     state_reg;
    logic [CW-1:0]              col_count_reg;
    logic [RW-1:0]              row_count_reg;
    logic [CW-1:0]              col_count_next;
    logic [RW-1:0]              row_count_next;
    logic [3:0]                 pending_reg;
    logic [3:0]                 pending_next;

    // Window and cell payload
    logic [PIXEL_W-1:0]         pix_reg;
    logic [PIXEL_W-1:0]         window_reg [3][2];
    logic [PIXEL_W-1:0]         g_reg [3][3];
    logic [2:0]                 rowok_reg;
    logic [2:0]                 colok_reg;
    logic [2:0]                 rowok_next;
    logic [2:0]                 colok_next;
    logic [CW-1:0]              c_lat_reg;
    logic [RW-1:0]              r_lat_reg;
    logic [SUM_W-1:0]           num_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       inband_reg;
    logic [PIXEL_W-1:0]         own_reg;
    logic [CW-1:0]              cell_col_reg;
    logic [RW-1:0]              cell_row_reg;
    logic                       last_reg;
    logic [PIXEL_W-1:0]         value_reg;
    logic                       none_reg;

    // Derived signals
    logic                       accept;
    logic [SZCW-1:0]            cols_eff;
    logic [SZRW-1:0]            rows_eff;
    logic                       lastc;
    logic                       lastr;
    logic [PIXEL_W-1:0]         upper_rdata;
    logic [PIXEL_W-1:0]         middle_rdata;
    logic [PIXEL_W-1:0]         col2 [3];
    logic [1:0]                 sel;
    logic [CW-1:0]              cell_col;
    logic [RW-1:0]              cell_row;
    logic [2:0]                 rowuse;
    logic [2:0]                 coluse;
    logic [SUM_W-1:0]           sum_c;
    logic [CNT_W-1:0]           cnt_c;
    logic [PIXEL_W-1:0]         own_c;
    logic [PW-1:0]              xc_u;
    logic [PW-1:0]              yc_u;
    logic signed [PW-1:0]       diff;
    logic                       inband_c;
    logic [PROD_W-1:0]          prod;
    logic [COL_XW-1:0]          col_ext;
    logic [ROW_XW-1:0]          row_ext;

    assign accept = pixels.valid && pixels.ready;

    // Register port: writes complete in the access phase, no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_reg_t'(paddr[APB_AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg      <= RST_GRID_COLS;
            grid_rows_reg      <= RST_GRID_ROWS;
            x_first_centre_reg <= RST_X_FIRST_CENTRE;
            y_first_centre_reg <= RST_Y_FIRST_CENTRE;
            bin_step_reg       <= RST_BIN_STEP;
            band_low_reg       <= RST_BAND_LOW;
            band_high_reg      <= RST_BAND_HIGH;
            x_limit_reg        <= RST_X_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_GRID_COLS:      grid_cols_reg      <= pwdata[GRID_SIZE_W-1:0];
                REG_GRID_ROWS:      grid_rows_reg      <= pwdata[GRID_SIZE_W-1:0];
                REG_X_FIRST_CENTRE: x_first_centre_reg <= pwdata[CENTRE_W-1:0];
                REG_Y_FIRST_CENTRE: y_first_centre_reg <= pwdata[CENTRE_W-1:0];
                REG_BIN_STEP:       bin_step_reg       <= pwdata[STEP_W-1:0];
                REG_BAND_LOW:       band_low_reg       <= signed'(pwdata[BAND_W-1:0]);
                REG_BAND_HIGH:      band_high_reg      <= signed'(pwdata[BAND_W-1:0]);
                REG_X_LIMIT:        x_limit_reg        <= pwdata[CENTRE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back of the addressed register
    always_comb
    begin
        prdata = '0;
        case (cfg_sel)
            REG_GRID_COLS:      prdata[GRID_SIZE_W-1:0] = grid_cols_reg;
            REG_GRID_ROWS:      prdata[GRID_SIZE_W-1:0] = grid_rows_reg;
            REG_X_FIRST_CENTRE: prdata[CENTRE_W-1:0]    = x_first_centre_reg;
            REG_Y_FIRST_CENTRE: prdata[CENTRE_W-1:0]    = y_first_centre_reg;
            REG_BIN_STEP:       prdata[STEP_W-1:0]      = bin_step_reg;
            REG_BAND_LOW:       prdata[BAND_W-1:0]      = band_low_reg;
            REG_BAND_HIGH:      prdata[BAND_W-1:0]      = band_high_reg;
            REG_X_LIMIT:        prdata[CENTRE_W-1:0]    = x_limit_reg;
            default:            prdata = '0;
        endcase
    end

    // Grid size clamped to 1..MAX
    always_comb
    begin
        if (grid_cols_reg == '0)
        begin
            cols_eff = SZCW'(1);
        end
        else if (SZCW'(grid_cols_reg) > SZCW'(MAX_COLS))
        begin
            cols_eff = SZCW'(MAX_COLS);
        end
        else
        begin
            cols_eff = SZCW'(grid_cols_reg);
        end

        if (grid_rows_reg == '0)
        begin
            rows_eff = SZRW'(1);
        end
        else if (SZRW'(grid_rows_reg) > SZRW'(MAX_ROWS))
        begin
            rows_eff = SZRW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = SZRW'(grid_rows_reg);
        end
    end

    assign lastc = SZCW'(col_count_reg) >= (cols_eff - SZCW'(1));
    assign lastr = SZRW'(row_count_reg) >= (rows_eff - SZRW'(1));

    // Counter advance at the end of a row and of the grid
    always_comb
    begin
        if (lastc)
        begin
            col_count_next = '0;
            row_count_next = lastr ? '0 : row_count_reg + RW'(1);
        end
        else
        begin
            col_count_next = col_count_reg + CW'(1);
            row_count_next = row_count_reg;
        end
    end

    // Cells released by this item, in raster order
    assign pending_next = {lastr && lastc,
                           lastr && (col_count_reg != '0),
                           (row_count_reg != '0) && lastc,
                           (row_count_reg != '0) && (col_count_reg != '0)};

    // Which window rows and columns fall inside the grid
    always_comb
    begin
        logic [RXW-1:0] rsum;
        logic [CXW-1:0] csum;
        for (int k = 0; k < 3; k++)
        begin
            rsum = RXW'(row_count_reg) + RXW'(k);
            csum = CXW'(col_count_reg) + CXW'(k);
            rowok_next[k] = (rsum >= RXW'(2)) && (rsum < RXW'(rows_eff) + RXW'(2));
            colok_next[k] = (csum >= CXW'(2)) && (csum < CXW'(cols_eff) + CXW'(2));
        end
    end

    // Line buffers: both are addressed by the column counter, which only moves at the
    // write-back edge, so the read at acceptance and the write-back share one address.
    bmnm_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_COLS)
    ) u_upper_line (
        .clk   (clk),
        .we    (state_reg == ST_LOAD),
        .addr  (col_count_reg),
        .wdata (middle_rdata),
        .rdata (upper_rdata)
    );

    bmnm_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_COLS)
    ) u_middle_line (
        .clk   (clk),
        .we    (state_reg == ST_LOAD),
        .addr  (col_count_reg),
        .wdata (pix_reg),
        .rdata (middle_rdata)
    );

    assign col2[0] = upper_rdata;
    assign col2[1] = middle_rdata;
    assign col2[2] = pix_reg;

    // Lowest pending cell goes first
    always_comb
    begin
        if (pending_reg[0])
        begin
            sel = 2'd0;
        end
        else if (pending_reg[1])
        begin
            sel = 2'd1;
        end
        else if (pending_reg[2])
        begin
            sel = 2'd2;
        end
        else
        begin
            sel = 2'd3;
        end
    end

    // Cell position: the upper bit of sel picks the lower row, the lower bit the right column
    assign cell_row = sel[1] ? r_lat_reg : r_lat_reg - RW'(1);
    assign cell_col = sel[0] ? c_lat_reg : c_lat_reg - CW'(1);

    // Masked neighbour sum and count for the selected cell
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rowuse[k] = rowok_reg[k] && !(sel[1] && (k == 0));
            coluse[k] = colok_reg[k] && !(sel[0] && (k == 0));
        end
        sum_c = '0;
        cnt_c = '0;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (rowuse[k] && coluse[j] && (g_reg[k][j] > THRESHOLD))
                begin
                    sum_c = sum_c + SUM_W'(g_reg[k][j]);
                    cnt_c = cnt_c + CNT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        case (sel)
            2'd0:    own_c = g_reg[1][1];
            2'd1:    own_c = g_reg[1][2];
            2'd2:    own_c = g_reg[2][1];
            default: own_c = g_reg[2][2];
        endcase
    end

    // Bin centres and the band test
    assign xc_u     = PW'(x_first_centre_reg) + PW'(cell_col) * PW'(bin_step_reg);
    assign yc_u     = PW'(y_first_centre_reg) + PW'(cell_row) * PW'(bin_step_reg);
    assign diff     = signed'(xc_u) - signed'(yc_u);
    assign inband_c = (xc_u <= PW'(x_limit_reg))
                      && (diff >= PW'(band_low_reg))
                      && (diff <= PW'(band_high_reg));

    // Rounded mean by the reciprocal of the count
    assign prod = PROD_W'(num_reg) * PROD_W'(recip(cnt_reg));

    // Sequencer and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_count_reg <= '0;
            row_count_reg <= '0;
            pending_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    col_count_reg <= col_count_next;
                    row_count_reg <= row_count_next;
                    pending_reg   <= pending_next;
                    state_reg     <= (pending_next != '0) ? ST_SUM : ST_IDLE;
                end
                ST_SUM:
                begin
                    pending_reg[sel] <= 1'b0;
                    state_reg        <= ST_DIV;
                end
                ST_DIV:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (results.ready)
                    begin
                        state_reg <= (pending_reg != '0) ? ST_SUM : ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= pixels.pixel_value;
        end

        // Build the 3x3 window and shift the column history along
        if (state_reg == ST_LOAD)
        begin
            for (int k = 0; k < 3; k++)
            begin
                g_reg[k][0]      <= window_reg[k][0];
                g_reg[k][1]      <= window_reg[k][1];
                g_reg[k][2]      <= col2[k];
                window_reg[k][0] <= window_reg[k][1];
                window_reg[k][1] <= col2[k];
            end
            rowok_reg <= rowok_next;
            colok_reg <= colok_next;
            c_lat_reg <= col_count_reg;
            r_lat_reg <= row_count_reg;
        end

        if (state_reg == ST_SUM)
        begin
            num_reg      <= sum_c + SUM_W'(cnt_c >> 1);
            cnt_reg      <= cnt_c;
            inband_reg   <= inband_c;
            own_reg      <= own_c;
            cell_col_reg <= cell_col;
            cell_row_reg <= cell_row;
            last_reg     <= (sel == 2'd3);
        end

        if (state_reg == ST_DIV)
        begin
            if (!inband_reg)
            begin
                value_reg <= own_reg;
                none_reg  <= 1'b0;
            end
            else if (cnt_reg == '0)
            begin
                value_reg <= '0;
                none_reg  <= 1'b1;
            end
            else
            begin
                value_reg <= prod[DIV_SHIFT +: PIXEL_W];
                none_reg  <= 1'b0;
            end
        end
    end

    // Channel outputs
    assign pixels.ready = (state_reg == ST_IDLE);

    assign col_ext = COL_XW'(cell_col_reg);
    assign row_ext = ROW_XW'(cell_row_reg);

    assign results.valid        = (state_reg == ST_OUT);
    assign results.out_row      = row_ext[OUT_POS_W-1:0];
    assign results.out_col      = col_ext[OUT_POS_W-1:0];
    assign results.out_value    = value_reg;
    assign results.was_filled   = inband_reg;
    assign results.no_neighbour = none_reg;
    assign results.frame_last   = last_reg;

endmodule

// ----- bench/mean_filter_checker.sv -----
// Checker: predicts the filtered cells from the watched channels and compares every result.
`timescale 1ns / 1ps

module mean_filter_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [bmnm_pkg::APB_AW-1:0] paddr,
    input  logic [bmnm_pkg::APB_DW-1:0] pwdata,
    input  logic [bmnm_pkg::APB_DW-1:0] prdata,
    bmnm_in_if                          pixels,
    bmnm_out_if                         results,
    output int                          fail_count,
    output int                          pending
);

    import bmnm_pkg::*;

    localparam int LINE_LEN  = DEF_MAX_COLS;
    localparam int ROW_LIMIT = DEF_MAX_ROWS;

    typedef struct packed {
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] col;
        logic [PIXEL_W-1:0]   value;
        logic                 filled;
        logic                 empty;
        logic                 last;
    } cell_result_t;

    // Register copies
    logic [GRID_SIZE_W-1:0]   cols_q;
    logic [GRID_SIZE_W-1:0]   rows_q;
    logic [CENTRE_W-1:0]      x_first_q;
    logic [CENTRE_W-1:0]      y_first_q;
    logic [STEP_W-1:0]        step_q;
    logic signed [BAND_W-1:0] band_lo_q;
    logic signed [BAND_W-1:0] band_hi_q;
    logic [CENTRE_W-1:0]      x_limit_q;

    // Filter state: two previous rows, two window columns of three rows, raster position
    logic [PIXEL_W-1:0] upper_line [LINE_LEN];
    logic [PIXEL_W-1:0] middle_line [LINE_LEN];
    logic [PIXEL_W-1:0] window_cells [6];
    int                 col_cnt;
    int                 row_cnt;

    cell_result_t       expected_cells [$];
    int                 errors;

    assign fail_count = errors;

    function automatic int reg_width(input cfg_reg_t idx);
        case (idx)
            REG_GRID_COLS, REG_GRID_ROWS:                     return GRID_SIZE_W;
            REG_X_FIRST_CENTRE, REG_Y_FIRST_CENTRE, REG_X_LIMIT: return CENTRE_W;
            REG_BIN_STEP:                                     return STEP_W;
            default:                                          return BAND_W;
        endcase
    endfunction

    function automatic logic [APB_DW-1:0] reg_value(input cfg_reg_t idx);
        case (idx)
            REG_GRID_COLS:      return APB_DW'(cols_q);
            REG_GRID_ROWS:      return APB_DW'(rows_q);
            REG_X_FIRST_CENTRE: return APB_DW'(x_first_q);
            REG_Y_FIRST_CENTRE: return APB_DW'(y_first_q);
            REG_BIN_STEP:       return APB_DW'(step_q);
            REG_BAND_LOW:       return APB_DW'(unsigned'(band_lo_q));
            REG_BAND_HIGH:      return APB_DW'(unsigned'(band_hi_q));
            default:            return APB_DW'(x_limit_q);
        endcase
    endfunction

    // One output cell: the masked mean of its clipped 3x3 neighbourhood when it lies in
    // the band, otherwise its own value. g row k is row rbase+k, g column j is cbase+j.
    function automatic cell_result_t filter_cell(input logic [PIXEL_W-1:0] g [3][3],
                                                 input int gk, input int gj,
                                                 input int rbase, input int cbase,
                                                 input int rows, input int cols,
                                                 input logic is_last);
        cell_result_t res;
        int           row_abs;
        int           col_abs;
        int           nb_row;
        int           nb_col;
        int           cnt;
        int unsigned  sum;
        longint       x_centre;
        longint       y_centre;
        longint       diff;
        logic         in_band;

        row_abs  = rbase + gk;
        col_abs  = cbase + gj;
        x_centre = longint'(x_first_q) + longint'(col_abs) * longint'(step_q);
        y_centre = longint'(y_first_q) + longint'(row_abs) * longint'(step_q);
        diff     = x_centre - y_centre;
        in_band  = (x_centre <= longint'(x_limit_q)) && (diff >= longint'(band_lo_q)) &&
                   (diff <= longint'(band_hi_q));

        res.row    = row_abs[OUT_POS_W-1:0];
        res.col    = col_abs[OUT_POS_W-1:0];
        res.value  = g[gk][gj];
        res.filled = in_band;
        res.empty  = 1'b0;
        res.last   = is_last;

        if (in_band)
        begin
            sum = 0;
            cnt = 0;
            for (int k = gk - 1; k <= gk + 1; k++)
            begin
                for (int j = gj - 1; j <= gj + 1; j++)
                begin
                    nb_row = rbase + k;
                    nb_col = cbase + j;
                    if (k >= 0 && k <= 2 && j >= 0 && j <= 2)
                    begin
                        if (nb_row >= 0 && nb_row < rows && nb_col >= 0 && nb_col < cols &&
                            g[k][j] > THRESHOLD)
                        begin
                            sum += g[k][j];
                            cnt++;
                        end
                    end
                end
            end
            // No neighbour above the threshold: the value is zero and the cell is flagged
            if (cnt == 0)
            begin
                res.value = '0;
                res.empty = 1'b1;
            end
            else
            begin
                res.value = PIXEL_W'((sum + cnt / 2) / cnt);
            end
        end
        return res;
    endfunction

    // Advance the raster by one accepted cell and queue the results that it completes.
    // Results trail the input by one row and one column; the last row and column flush.
    task automatic predict_pixel(input logic [PIXEL_W-1:0] pix);
        logic [PIXEL_W-1:0] g [3][3];
        int                 cols;
        int                 rows;
        int                 c;
        int                 r;
        logic               last_col;
        logic               last_row;

        // Out-of-range sizes act as the nearest legal size
        cols = (cols_q == 0) ? 1 : ((cols_q > LINE_LEN) ? LINE_LEN : int'(cols_q));
        rows = (rows_q == 0) ? 1 : ((rows_q > ROW_LIMIT) ? ROW_LIMIT : int'(rows_q));
        c = (col_cnt >= LINE_LEN) ? LINE_LEN - 1 : col_cnt;
        r = (row_cnt >= ROW_LIMIT) ? ROW_LIMIT - 1 : row_cnt;
        // A counter beyond a shrunken size is taken as the last index
        last_col = (c >= cols - 1);
        last_row = (r >= rows - 1);

        for (int k = 0; k < 3; k++)
        begin
            g[k][0] = window_cells[2 * k];
            g[k][1] = window_cells[2 * k + 1];
        end
        g[0][2] = upper_line[c];
        g[1][2] = middle_line[c];
        g[2][2] = pix;

        if (r >= 1 && c >= 1)
            expected_cells.push_back(filter_cell(g, 1, 1, r - 2, c - 2, rows, cols, 1'b0));
        if (r >= 1 && last_col)
            expected_cells.push_back(filter_cell(g, 1, 2, r - 2, c - 2, rows, cols, 1'b0));
        if (last_row && c >= 1)
            expected_cells.push_back(filter_cell(g, 2, 1, r - 2, c - 2, rows, cols, 1'b0));
        if (last_row && last_col)
            expected_cells.push_back(filter_cell(g, 2, 2, r - 2, c - 2, rows, cols, 1'b1));

        for (int k = 0; k < 3; k++)
        begin
            window_cells[2 * k]     = g[k][1];
            window_cells[2 * k + 1] = g[k][2];
        end
        upper_line[c]  = middle_line[c];
        middle_line[c] = pix;

        if (last_col)
        begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : r + 1;
        end
        else
        begin
            col_cnt = c + 1;
            row_cnt = r;
        end
    endtask

    task automatic check_field(input string what, input cell_result_t want,
                               input logic [PIXEL_W-1:0] exp_val,
                               input logic [PIXEL_W-1:0] got_val);
        if (got_val !== exp_val)
        begin
            $display("%0t: cell (%0d,%0d) %s mismatch: expected %h, got %h",
                     $time, want.row, want.col, what, exp_val, got_val);
            errors++;
        end
    endtask

    // Register port, cell channel and result channel, all sampled at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t want;
        cfg_reg_t     idx;
        logic [APB_DW-1:0] mask;

        if (!rst_n)
        begin
            cols_q    = RST_GRID_COLS;
            rows_q    = RST_GRID_ROWS;
            x_first_q = RST_X_FIRST_CENTRE;
            y_first_q = RST_Y_FIRST_CENTRE;
            step_q    = RST_BIN_STEP;
            band_lo_q = RST_BAND_LOW;
            band_hi_q = RST_BAND_HIGH;
            x_limit_q = RST_X_LIMIT;
            foreach (upper_line[i])
            begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            foreach (window_cells[i])
                window_cells[i] = '0;
            col_cnt = 0;
            row_cnt = 0;
            expected_cells.delete();
            pending <= 0;
        end
        else
        begin
            // Register writes update the copies; reads are compared with them
            if (psel && penable && pready)
            begin
                idx = cfg_reg_t'(paddr[APB_AW-1:2]);
                if (pwrite)
                begin
                    case (idx)
                        REG_GRID_COLS:      cols_q    = pwdata[GRID_SIZE_W-1:0];
                        REG_GRID_ROWS:      rows_q    = pwdata[GRID_SIZE_W-1:0];
                        REG_X_FIRST_CENTRE: x_first_q = pwdata[CENTRE_W-1:0];
                        REG_Y_FIRST_CENTRE: y_first_q = pwdata[CENTRE_W-1:0];
                        REG_BIN_STEP:       step_q    = pwdata[STEP_W-1:0];
                        REG_BAND_LOW:       band_lo_q = pwdata[BAND_W-1:0];
                        REG_BAND_HIGH:      band_hi_q = pwdata[BAND_W-1:0];
                        default:            x_limit_q = pwdata[CENTRE_W-1:0];
                    endcase
                end
                else
                begin
                    mask = (APB_DW'(1) << reg_width(idx)) - 1;
                    if ((prdata & mask) !== reg_value(idx))
                    begin
                        $display("%0t: register %s read mismatch: expected %h, got %h",
                                 $time, idx.name(), reg_value(idx), prdata & mask);
                        errors++;
                    end
                end
            end

            if (pixels.valid && pixels.ready)
                predict_pixel(pixels.pixel_value);

            if (results.valid && results.ready)
            begin
                if (expected_cells.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got cell (%0d,%0d) %h",
                             $time, results.out_row, results.out_col, results.out_value);
                    errors++;
                end
                else
                begin
                    want = expected_cells.pop_front();
                    check_field("out_row", want, PIXEL_W'(want.row), PIXEL_W'(results.out_row));
                    check_field("out_col", want, PIXEL_W'(want.col), PIXEL_W'(results.out_col));
                    check_field("out_value", want, want.value, results.out_value);
                    check_field("was_filled", want, PIXEL_W'(want.filled),
                                PIXEL_W'(results.was_filled));
                    check_field("no_neighbour", want, PIXEL_W'(want.empty),
                                PIXEL_W'(results.no_neighbour));
                    check_field("frame_last", want, PIXEL_W'(want.last),
                                PIXEL_W'(results.frame_last));
                end
            end

            pending <= expected_cells.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top: clock, reset, register set-up, grid stimulus and the final verdict.
`timescale 1ns / 1ps

module tb;
    import bmnm_pkg::*;

    localparam int RESET_CYCLES     = 6;
    localparam int SETTLE_CYCLES    = 20;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int ITEMS_PER_PHASE  = 10;
    localparam int HEAVY_IDLE_PCT   = 58;
    localparam int LIGHT_IDLE_PCT   = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic              pready;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    int                gap_pct;
    int                stall_pct;
    int                cycle_count;
    int                fail_count;
    int                cells_pending;

    bmnm_in_if  pix_if ();
    bmnm_out_if res_if ();

    banded_masked_neighbour_mean i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pixels  (pix_if),
        .results (res_if)
    );

    mean_filter_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pixels     (pix_if),
        .results    (res_if),
        .fail_count (fail_count),
        .pending    (cells_pending)
    );

    always #1 clk = ~clk;

    // The result side stalls at random, at the rate of the current phase
    always @(posedge clk)
        res_if.ready <= ($urandom_range(0, 99) >= stall_pct);

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                gap_pct   = HEAVY_IDLE_PCT;
                stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                gap_pct   = 0;
                stall_pct = HEAVY_IDLE_PCT;
            end
            IDLE_BOTH:
            begin
                gap_pct   = LIGHT_IDLE_PCT;
                stall_pct = LIGHT_IDLE_PCT;
            end
            default:
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    // One register access; psel stays high so that accesses can follow back to back
    task automatic reg_access(input cfg_reg_t idx, input logic is_write,
                              input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic reg_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [APB_DW-1:0] field_bits(input int v, input int w);
        return APB_DW'(v) & ((APB_DW'(1) << w) - 1);
    endfunction

    // Writes every register, then reads them all back for the checker to compare
    task automatic write_config(input int cols, input int rows, input int x0, input int y0,
                                input int step, input int lo, input int hi, input int xl);
        reg_access(REG_GRID_COLS, 1'b1, field_bits(cols, GRID_SIZE_W));
        reg_access(REG_GRID_ROWS, 1'b1, field_bits(rows, GRID_SIZE_W));
        reg_access(REG_X_FIRST_CENTRE, 1'b1, field_bits(x0, CENTRE_W));
        reg_access(REG_Y_FIRST_CENTRE, 1'b1, field_bits(y0, CENTRE_W));
        reg_access(REG_BIN_STEP, 1'b1, field_bits(step, STEP_W));
        reg_access(REG_BAND_LOW, 1'b1, field_bits(lo, BAND_W));
        reg_access(REG_BAND_HIGH, 1'b1, field_bits(hi, BAND_W));
        reg_access(REG_X_LIMIT, 1'b1, field_bits(xl, CENTRE_W));
        for (int i = REG_GRID_COLS; i <= REG_X_LIMIT; i++)
            reg_access(cfg_reg_t'(i), 1'b0, '0);
        reg_idle();
    endtask

    // Mostly a band placed across the grid's diagonals so that filled and passed
    // cells mix; now and then fully random band limits and x limit.
    task automatic random_config(input int cols_reg, input int rows_reg);
        int step;
        int x0;
        int y0;
        int lo;
        int hi;
        int xl;
        int a;
        int b;
        int span;

        span = (cols_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : cols_reg;
        case ($urandom_range(0, 7))
            0:       step = 1;
            1:       step = 255;
            default: step = $urandom_range(1, 255);
        endcase
        x0 = ($urandom_range(0, 7) == 0) ? 4095 : int'($urandom_range(0, 4095));
        y0 = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(0, 4095));
        if ($urandom_range(0, 4) == 0)
        begin
            lo = int'($urandom_range(0, 8191)) - 4096;
            hi = int'($urandom_range(0, 8191)) - 4096;
            xl = $urandom_range(0, 4095);
        end
        else
        begin
            a  = int'($urandom_range(0, 6)) - 3;
            b  = int'($urandom_range(0, 6)) - 3;
            lo = x0 - y0 + ((a < b) ? a : b) * step;
            hi = x0 - y0 + ((a < b) ? b : a) * step;
            xl = x0 + int'($urandom_range(0, span)) * step;
        end
        lo = (lo < -4096) ? -4096 : ((lo > 4095) ? 4095 : lo);
        hi = (hi < -4096) ? -4096 : ((hi > 4095) ? 4095 : hi);
        xl = (xl > 4095) ? 4095 : xl;
        write_config(cols_reg, rows_reg, x0, y0, step, lo, hi, xl);
    endtask

    // Values around the threshold are common so that empty neighbourhoods occur
    function automatic logic [PIXEL_W-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0, 1, 2: return PIXEL_W'($urandom_range(0, 8));
            3:       return '1;
            default: return PIXEL_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [PIXEL_W-1:0] value);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_value <= value;
        do @(posedge clk); while (!pix_if.ready);
    endtask

    // Stop sending until every queued result has come, then let the block settle
    task automatic hold_until_drained();
        pix_if.valid <= 1'b0;
        do @(posedge clk); while (cells_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (gap_pct > 0 && $urandom_range(0, 29) == 0)
                hold_until_drained();
            send_pixel(random_pixel());
        end
    endtask

    initial
    begin
        logic [PIXEL_W-1:0] edge_cells [9];
        int                 sent;
        int                 ncols;
        int                 nrows;

        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        pix_if.valid       <= 1'b0;
        pix_if.pixel_value <= '0;
        set_idle_mode(IDLE_NONE);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of all registers
        for (int i = REG_GRID_COLS; i <= REG_X_LIMIT; i++)
            reg_access(cfg_reg_t'(i), 1'b0, '0);
        reg_idle();

        // Whole 3x3 grid in the widest band: full-scale means, values at and just
        // above the threshold
        write_config(3, 3, 0, 0, 1, -4096, 4095, 4095);
        edge_cells = '{16'hFFFF, 16'hFFFF, 16'd4,
                       16'hFFFF, 16'hFFFF, 16'd5,
                       16'd0,    16'd1,    16'hFFFF};
        foreach (edge_cells[i])
            send_pixel(edge_cells[i]);

        // 2x2 grid where no neighbour exceeds the threshold
        hold_until_drained();
        write_config(2, 2, 0, 0, 1, -4096, 4095, 4095);
        send_pixel(16'd4);
        send_pixel(16'd0);
        send_pixel(16'd3);
        send_pixel(16'd4);

        // Zero grid size acts as a single cell: once in the band, once outside it
        hold_until_drained();
        write_config(0, 0, 0, 0, 1, -4096, 4095, 4095);
        send_pixel(16'h8000);
        hold_until_drained();
        write_config(0, 0, 4095, 0, 255, 1, 4095, 0);
        send_pixel(16'h7FFF);

        // Column count shrunk part way through a grid
        hold_until_drained();
        random_config(4, 3);
        repeat (6) send_pixel(random_pixel());
        hold_until_drained();
        reg_access(REG_GRID_COLS, 1'b1, field_bits(2, GRID_SIZE_W));
        reg_idle();
        repeat (3) send_pixel(random_pixel());

        // Random grids under each idling pattern; one full-width row with a column
        // count above the maximum runs under receiver stalls
        for (int m = IDLE_NONE; m <= IDLE_BOTH; m++)
        begin
            set_idle_mode(idle_mode_t'(m));
            sent = 0;
            if (m == IDLE_RECEIVER)
            begin
                hold_until_drained();
                random_config(127, 1);
                send_frame(DEF_MAX_COLS);
                sent = DEF_MAX_COLS;
            end
            while (sent < ITEMS_PER_PHASE)
            begin
                ncols = $urandom_range(1, 8);
                nrows = $urandom_range(1, 6);
                hold_until_drained();
                random_config(ncols, nrows);
                send_frame(ncols * nrows);
                sent += ncols * nrows;
            end
        end

        hold_until_drained();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/bmnm_pkg.sv
sv/bmnm_if.sv
sv/bmnm_ram.sv
sv/banded_masked_neighbour_mean.sv
bench/mean_filter_checker.sv
bench/tb.sv
